@@ sv/assert_macros.svh @@
// Assertion macros included by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BFSA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BFSA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define BFSA_ASSERT(label, clk, rst_n, prop, msg)
`define BFSA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ sv/bfsa_pkg.sv @@
package bfsa_pkg;

  localparam int MaxSegments = 16;
  localparam int SlotBits    = $clog2(MaxSegments);
  localparam int CountBits   = SlotBits + 1;
  localparam int AddrBits    = 16;
  localparam int IdBits      = 16;
  localparam int TimeBits    = 24;
  localparam int UsedBits    = AddrBits + SlotBits;
  localparam int CmdBits     = 3;
  localparam int StatusBits  = 3;
  localparam int InDataBits  = 80;
  localparam int OutDataBits = 72;

  localparam logic [AddrBits-1:0] ResetMemSize = AddrBits'(1024);

  typedef enum logic [CmdBits-1:0] {
    CmdAdd     = 3'd0,
    CmdRemove  = 3'd1,
    CmdAdvance = 3'd2,
    CmdCompact = 3'd3,
    CmdProbe   = 3'd4
  } cmd_e;

  typedef enum logic [StatusBits-1:0] {
    StOk        = 3'd0,
    StIdPresent = 3'd1,
    StIdUnknown = 3'd2,
    StNoHole    = 3'd3,
    StTableFull = 3'd4
  } status_e;

endpackage

@@ sv/best_fit_segment_allocator.sv @@
// Channel  | Dir | Signals                 | Word
// ---------+-----+-------------------------+-----------------------------------------
// command  | in  | s_tvalid/tready/tdata/tuser | tuser: cmd; tdata: id, size, time, delta
// result   | out | m_tvalid/tready/tdata/tuser | tuser: status; tdata: result fields
// config   | in  | cfg_we/cfg_wdata        | memory size, taken at once
//
// One command starts with a scan of all 16 table slots, then runs one or two
// address-order walks. A walk visits each resident segment with a search of the
// slot table plus one step, then closes with one more search and step; add and
// compact run two walks. A single slot-table read port sets the pace.
// Reset empties the table and sets the memory size to 1024; a result waiting on
// the output does not keep the block from taking the next command.
`include "assert_macros.svh"

module best_fit_segment_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bfsa_pkg::AddrBits-1:0]      cfg_wdata_i,
  input  logic                               s_tvalid_i,
  output logic                               s_tready_o,
  // owner_id[15:0], request_size[31:16], run_time[55:32], time_delta[79:56]
  input  logic [bfsa_pkg::InDataBits-1:0]    s_tdata_i,
  // cmd[2:0]
  input  logic [bfsa_pkg::CmdBits-1:0]       s_tuser_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  // placed_at[15:0], hole_found[16], hole_size[32:17], freed_count[37:33],
  // free_total[53:38], first_free[70:54], no_segments[71]
  output logic [bfsa_pkg::OutDataBits-1:0]   m_tdata_o,
  // status[2:0]
  output logic [bfsa_pkg::StatusBits-1:0]    m_tuser_o
);
  import bfsa_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StScan, StSrch, StStep, StInsert, StDone
  } state_e;

  state_e state_q;

  // Slot table.
  logic [MaxSegments-1:0] valid_q;
  logic [IdBits-1:0]      owner_q [MaxSegments];
  logic [AddrBits-1:0]    base_q  [MaxSegments];
  logic [AddrBits-1:0]    len_q   [MaxSegments];
  logic [TimeBits-1:0]    time_q  [MaxSegments];

  logic [AddrBits-1:0] mem_q;

  // Latched command.
  cmd_e                cmd_q;
  logic [IdBits-1:0]   id_q;
  logic [AddrBits-1:0] req_q;
  logic [TimeBits-1:0] rt_q;
  logic [TimeBits-1:0] dt_q;

  // Sequencer and walk registers.
  logic [SlotBits-1:0]  idx_q;
  logic                 final_q;
  logic                 hit_q;
  logic                 free_v_q;
  logic [SlotBits-1:0]  free_idx_q;
  logic [CountBits-1:0] freed_cnt_q;
  logic                 cand_q;
  logic [SlotBits-1:0]  cand_idx_q;
  logic [AddrBits-1:0]  cand_base_q;
  logic [AddrBits-1:0]  cand_len_q;
  logic                 have_last_q;
  logic [AddrBits-1:0]  last_base_q;
  logic [AddrBits:0]    fit_cur_q;
  logic                 best_v_q;
  logic [AddrBits-1:0]  best_size_q;
  logic [AddrBits-1:0]  best_addr_q;
  logic [AddrBits:0]    cmp_cur_q;
  logic [AddrBits:0]    stat_cur_q;
  logic [UsedBits-1:0]  used_q;
  logic                 gap_q;
  logic [CountBits-1:0] count_q;

  // Output register.
  logic                  m_valid_q;
  logic [StatusBits-1:0] status_q;
  logic [AddrBits-1:0]   placed_q;
  logic                  found_q;
  logic [AddrBits-1:0]   hsize_q;
  logic [CountBits-1:0]  freed_q;
  logic [AddrBits-1:0]   free_total_q;
  logic [AddrBits:0]     first_free_q;
  logic                  no_seg_q;

  // Table read at the sequencer index.
  logic                rd_valid;
  logic [IdBits-1:0]   rd_owner;
  logic [AddrBits-1:0] rd_base;
  logic [AddrBits-1:0] rd_len;
  logic [TimeBits-1:0] rd_time;
  logic                idx_last;
  logic                match;
  logic                expire;
  logic                better;

  assign rd_valid = valid_q[idx_q];
  assign rd_owner = owner_q[idx_q];
  assign rd_base  = base_q[idx_q];
  assign rd_len   = len_q[idx_q];
  assign rd_time  = time_q[idx_q];
  assign idx_last = (idx_q == SlotBits'(MaxSegments - 1));
  assign match    = rd_valid && (rd_owner == id_q);
  assign expire   = (rd_time <= dt_q);
  assign better   = rd_valid && (!have_last_q || rd_base > last_base_q) &&
                    (!cand_q || rd_base < cand_base_q);

  // Hole check for the current walk step.
  logic              fit_en;
  logic [AddrBits:0] end_addr;
  logic [AddrBits:0] fit_hole;
  logic [AddrBits:0] cand_end;
  logic              fit_take;
  logic              compact_pass;
  logic              ins_ok;

  assign fit_en       = (req_q != '0) &&
                        ((cmd_q == CmdAdd && !final_q) || cmd_q == CmdProbe);
  assign end_addr     = cand_q ? {1'b0, cand_base_q} : {1'b0, mem_q};
  assign fit_hole     = end_addr - fit_cur_q;
  assign cand_end     = {1'b0, cand_base_q} + {1'b0, cand_len_q};
  assign fit_take     = fit_en && (end_addr > fit_cur_q) && (fit_hole >= {1'b0, req_q}) &&
                        (!best_v_q || fit_hole < {1'b0, best_size_q});
  assign compact_pass = (cmd_q == CmdCompact) && !final_q;
  assign ins_ok       = (state_q == StInsert) && (cmd_q == CmdAdd) && !hit_q &&
                        best_v_q && free_v_q;

  // Result word.
  logic [StatusBits-1:0] res_status;
  logic [AddrBits-1:0]   res_free;
  logic [AddrBits:0]     res_first;

  always_comb begin
    case (cmd_q)
      CmdAdd: begin
        if (hit_q)          res_status = StIdPresent;
        else if (!best_v_q) res_status = StNoHole;
        else if (!free_v_q) res_status = StTableFull;
        else                res_status = StOk;
      end
      CmdRemove: res_status = hit_q ? StOk : StIdUnknown;
      CmdProbe: begin
        if (hit_q)          res_status = StIdPresent;
        else if (!best_v_q) res_status = StNoHole;
        else                res_status = StOk;
      end
      default: res_status = StOk;
    endcase
    res_free  = ({{SlotBits{1'b0}}, mem_q} >= used_q) ?
                (mem_q - used_q[AddrBits-1:0]) : '0;
    res_first = (gap_q || stat_cur_q < {1'b0, mem_q}) ?
                stat_cur_q : ({1'b0, mem_q} + (AddrBits+1)'(1));
  end

  // Slot payload writes.
  always_ff @(posedge clk_i) begin
    if (state_q == StScan && cmd_q == CmdAdvance && rd_valid && !expire) begin
      time_q[idx_q] <= rd_time - dt_q;
    end
    if (state_q == StStep && cand_q && compact_pass) begin
      base_q[cand_idx_q] <= cmp_cur_q[AddrBits-1:0];
    end
    if (ins_ok) begin
      owner_q[free_idx_q] <= id_q;
      base_q[free_idx_q]  <= best_addr_q;
      len_q[free_idx_q]   <= req_q;
      time_q[free_idx_q]  <= rt_q;
    end
  end

  // Sequencer, valid bits and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      valid_q     <= '0;
      mem_q       <= ResetMemSize;
      m_valid_q   <= 1'b0;
      idx_q       <= '0;
      final_q     <= 1'b0;
      hit_q       <= 1'b0;
      free_v_q    <= 1'b0;
      free_idx_q  <= '0;
      freed_cnt_q <= '0;
      cand_q      <= 1'b0;
      cand_idx_q  <= '0;
      cand_base_q <= '0;
      cand_len_q  <= '0;
      have_last_q <= 1'b0;
      last_base_q <= '0;
      fit_cur_q   <= '0;
      best_v_q    <= 1'b0;
      best_size_q <= '0;
      best_addr_q <= '0;
      cmp_cur_q   <= '0;
      stat_cur_q  <= '0;
      used_q      <= '0;
      gap_q       <= 1'b0;
      count_q     <= '0;
      cmd_q       <= CmdAdd;
      id_q        <= '0;
      req_q       <= '0;
      rt_q        <= '0;
      dt_q        <= '0;
      status_q    <= '0;
      placed_q    <= '0;
      found_q     <= 1'b0;
      hsize_q     <= '0;
      freed_q     <= '0;
      free_total_q <= '0;
      first_free_q <= '0;
      no_seg_q    <= 1'b0;
    end else begin
      // The result register drains here unless a new word is loaded below.
      if (m_valid_q && m_tready_i && state_q != StDone) begin
        m_valid_q <= 1'b0;
      end
      // A new memory size empties the table.
      if (cfg_we_i) begin
        mem_q   <= cfg_wdata_i;
        valid_q <= '0;
      end
      case (state_q)
        StIdle: begin
          if (s_tvalid_i) begin
            cmd_q       <= cmd_e'(s_tuser_i);
            id_q        <= s_tdata_i[15:0];
            req_q       <= s_tdata_i[31:16];
            rt_q        <= s_tdata_i[55:32];
            dt_q        <= s_tdata_i[79:56];
            idx_q       <= '0;
            hit_q       <= 1'b0;
            free_v_q    <= 1'b0;
            freed_cnt_q <= '0;
            state_q     <= StScan;
          end
        end
        // Owner lookup, free slot search, expiry and removal.
        StScan: begin
          if (match) begin
            hit_q <= 1'b1;
            if (cmd_q == CmdRemove) valid_q[idx_q] <= 1'b0;
          end
          if (!rd_valid && !free_v_q) begin
            free_v_q   <= 1'b1;
            free_idx_q <= idx_q;
          end
          if (cmd_q == CmdAdvance && rd_valid && expire) begin
            valid_q[idx_q] <= 1'b0;
            freed_cnt_q    <= freed_cnt_q + CountBits'(1);
          end
          idx_q <= idx_q + SlotBits'(1);
          if (idx_last) begin
            final_q     <= !(cmd_q == CmdAdd || cmd_q == CmdCompact);
            fit_cur_q   <= '0;
            best_v_q    <= 1'b0;
            best_size_q <= '0;
            best_addr_q <= '0;
            cand_q      <= 1'b0;
            have_last_q <= 1'b0;
            cmp_cur_q   <= '0;
            stat_cur_q  <= '0;
            used_q      <= '0;
            gap_q       <= 1'b0;
            count_q     <= '0;
            state_q     <= StSrch;
          end
        end
        // Find the lowest base above the last visited one.
        StSrch: begin
          if (better) begin
            cand_q      <= 1'b1;
            cand_idx_q  <= idx_q;
            cand_base_q <= rd_base;
            cand_len_q  <= rd_len;
          end
          idx_q <= idx_q + SlotBits'(1);
          if (idx_last) state_q <= StStep;
        end
        // Visit one segment, or close the walk at the top of memory.
        StStep: begin
          if (fit_take) begin
            best_v_q    <= 1'b1;
            best_size_q <= fit_hole[AddrBits-1:0];
            best_addr_q <= fit_cur_q[AddrBits-1:0];
          end
          if (cand_q) begin
            fit_cur_q   <= cand_end;
            used_q      <= used_q + UsedBits'(cand_len_q);
            if (!gap_q) begin
              if ({1'b0, cand_base_q} > stat_cur_q) gap_q <= 1'b1;
              else stat_cur_q <= cand_end;
            end
            cmp_cur_q   <= cmp_cur_q + {1'b0, cand_len_q};
            count_q     <= count_q + CountBits'(1);
            have_last_q <= 1'b1;
            last_base_q <= cand_base_q;
            cand_q      <= 1'b0;
            idx_q       <= '0;
            state_q     <= StSrch;
          end else if (final_q) begin
            state_q <= StDone;
          end else if (cmd_q == CmdAdd) begin
            state_q <= StInsert;
          end else begin
            final_q     <= 1'b1;
            have_last_q <= 1'b0;
            stat_cur_q  <= '0;
            used_q      <= '0;
            gap_q       <= 1'b0;
            count_q     <= '0;
            idx_q       <= '0;
            state_q     <= StSrch;
          end
        end
        // Place the new segment, then walk again for the totals.
        StInsert: begin
          if (ins_ok) valid_q[free_idx_q] <= 1'b1;
          final_q     <= 1'b1;
          have_last_q <= 1'b0;
          stat_cur_q  <= '0;
          used_q      <= '0;
          gap_q       <= 1'b0;
          count_q     <= '0;
          idx_q       <= '0;
          state_q     <= StSrch;
        end
        StDone: begin
          if (!m_valid_q || m_tready_i) begin
            m_valid_q    <= 1'b1;
            status_q     <= res_status;
            placed_q     <= (cmd_q == CmdAdd && res_status == StOk) ? best_addr_q : '0;
            found_q      <= (cmd_q == CmdProbe && res_status == StOk);
            hsize_q      <= (cmd_q == CmdProbe && res_status == StOk) ? best_size_q : '0;
            freed_q      <= freed_cnt_q;
            free_total_q <= res_free;
            first_free_q <= res_first;
            no_seg_q     <= (count_q == '0);
            state_q      <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_tready_o = (state_q == StIdle);
  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {no_seg_q, first_free_q, free_total_q, freed_q,
                       hsize_q, found_q, placed_q};
  assign m_tuser_o  = status_q;

  // An empty memory reports all of it as free.
  `BFSA_ASSERT_IMPLIES(a_empty_all_free, clk_i, rst_ni, m_valid_q && no_seg_q, free_total_q == mem_q, "empty memory with free total short of its size")
  // A found hole comes with status ok and a nonzero size.
  `BFSA_ASSERT_IMPLIES(a_hole_ok, clk_i, rst_ni, m_valid_q && found_q, status_q == StOk && hsize_q != '0, "hole reported with bad status or size")
  // The last search cycle always hands over to a walk step.
  `BFSA_ASSERT(a_search_to_step, clk_i, rst_ni, (state_q == StSrch && idx_last) |=> (state_q == StStep), "search did not end in a walk step")

endmodule
